// ===== rtl/mmad_pkg.sv =====
// shared types and constants for the masked overlap mean absolute difference block
package mmad_pkg;

  localparam int unsigned PixW     = 16;
  localparam int unsigned DimW     = 13;
  localparam int unsigned SumW     = 40;
  localparam int unsigned CntW     = 25;
  localparam int unsigned MeanW    = 24;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // restoring divider: one quotient bit per cycle
  localparam int unsigned DivSteps = MeanW;
  localparam int unsigned StepW    = $clog2(DivSteps);
  // frac bits appended below the sum
  localparam int unsigned FracW    = 8;

  localparam logic [CntW-1:0]  MeanMax       = CntW'(16776960);
  localparam logic [DimW-1:0]  RstRefWidth   = DimW'(4096);
  localparam logic [DimW-1:0]  RstCandWidth  = DimW'(4096);
  localparam logic [DimW-1:0]  RstCandHeight = DimW'(4096);
  localparam logic [PixW-1:0]  RstAlphaThr   = PixW'(32512);

  typedef enum logic [CfgIdxW-1:0] {
    REG_REF_WIDTH   = 3'd0,
    REG_CAND_WIDTH  = 3'd1,
    REG_CAND_HEIGHT = 3'd2,
    REG_OFFSET_X    = 3'd3,
    REG_OFFSET_Y    = 3'd4,
    REG_ALPHA_THR   = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_e;

  typedef struct packed {
    logic        [DimW-1:0] ref_width;
    logic        [DimW-1:0] cand_width;
    logic        [DimW-1:0] cand_height;
    logic signed [DimW-1:0] offset_x;
    logic signed [DimW-1:0] offset_y;
    logic        [PixW-1:0] alpha_threshold;
  } cfg_t;

  typedef struct packed {
    logic [SumW-1:0] sum;
    logic [CntW-1:0] count;
  } frame_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== rtl/mmad_front.sv =====
// pixel front end: raster position, overlap and alpha test, frame accumulators
module mmad_front #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mmad_pkg::cfg_t                    cfg_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [mmad_pkg::PixW-1:0]         ref_red_i,
  input  logic [mmad_pkg::PixW-1:0]         ref_alpha_i,
  input  logic [mmad_pkg::PixW-1:0]         cand_red_i,
  input  logic [mmad_pkg::PixW-1:0]         cand_alpha_i,
  input  logic                              last_i,
  input  mmad_pkg::q_status_t               q_status_i,
  output logic                              push_o,
  output mmad_pkg::frame_t                  push_data_o
);

  localparam int unsigned CW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned EW = ((CW > mmad_pkg::DimW) ? CW : mmad_pkg::DimW) + 2;
  localparam int unsigned SW = EW + 1;
  localparam logic [EW-1:0] MaxDimE = EW'(MAX_DIM);

  logic [CW-1:0]             column_q, column_d;
  logic [CW-1:0]             row_q, row_d;
  logic [mmad_pkg::SumW-1:0] sum_q, sum_d, sum_n;
  logic [mmad_pkg::CntW-1:0] count_q, count_d, count_n;

  logic                      accept;
  logic signed [SW-1:0]      dx, dy, cw_s, ch_s;
  logic                      in_overlap, qualify;
  logic [mmad_pkg::PixW-1:0] abs_diff;
  logic [EW-1:0]             ref_w, eff_w, col_inc, row_inc;
  logic                      col_wrap, row_wrap;

  assign in_ready_o = !(last_i && q_status_i.full);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    dx   = signed'(SW'(column_q)) - SW'(cfg_i.offset_x);
    dy   = signed'(SW'(row_q)) - SW'(cfg_i.offset_y);
    cw_s = signed'(SW'(cfg_i.cand_width));
    ch_s = signed'(SW'(cfg_i.cand_height));
    in_overlap = !dx[SW-1] && (dx < cw_s) && !dy[SW-1] && (dy < ch_s);
    // saturated count stops both sum and count
    qualify = in_overlap && (ref_alpha_i > cfg_i.alpha_threshold)
              && (cand_alpha_i > cfg_i.alpha_threshold) && !count_q[mmad_pkg::CntW-1];
    abs_diff = (ref_red_i > cand_red_i) ? (ref_red_i - cand_red_i) : (cand_red_i - ref_red_i);
    sum_n   = qualify ? (sum_q + mmad_pkg::SumW'(abs_diff)) : sum_q;
    count_n = count_q + mmad_pkg::CntW'(qualify);

    ref_w = EW'(cfg_i.ref_width);
    priority if (ref_w == '0) begin
      eff_w = EW'(1);
    end else if (ref_w > MaxDimE) begin
      eff_w = MaxDimE;
    end else begin
      eff_w = ref_w;
    end
    col_inc  = EW'(column_q) + EW'(1);
    row_inc  = EW'(row_q) + EW'(1);
    col_wrap = col_inc >= eff_w;
    row_wrap = row_inc >= MaxDimE;

    column_d = column_q;
    row_d    = row_q;
    sum_d    = sum_q;
    count_d  = count_q;
    if (accept) begin
      if (last_i) begin
        column_d = '0;
        row_d    = '0;
        sum_d    = '0;
        count_d  = '0;
      end else begin
        sum_d   = sum_n;
        count_d = count_n;
        if (col_wrap) begin
          column_d = '0;
          row_d    = row_wrap ? '0 : row_inc[CW-1:0];
        end else begin
          column_d = col_inc[CW-1:0];
        end
      end
    end
  end

  assign push_o            = accept && last_i;
  assign push_data_o.sum   = sum_n;
  assign push_data_o.count = count_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q <= '0;
      row_q    <= '0;
      sum_q    <= '0;
      count_q  <= '0;
    end else begin
      column_q <= column_d;
      row_q    <= row_d;
      sum_q    <= sum_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== rtl/mmad_queue.sv =====
// two-entry queue of frame totals between the front end and the divider
module mmad_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  mmad_pkg::frame_t    push_data_i,
  input  logic                pop_i,
  output mmad_pkg::frame_t    head_o,
  output mmad_pkg::q_status_t status_o
);

  mmad_pkg::frame_t entry_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       fill_q, fill_d;

  assign status_o.full  = (fill_q == 2'd2);
  assign status_o.empty = (fill_q == 2'd0);
  assign head_o         = entry_q[rd_ptr_q];

  always_comb begin
    fill_d = fill_q;
    unique case ({push_i, pop_i})
      2'b10:   fill_d = fill_q + 2'd1;
      2'b01:   fill_d = fill_q - 2'd1;
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      fill_q <= fill_d;
    end
  end

endmodule

// ===== rtl/mmad_div.sv =====
// back end: serial restoring divide of sum*256 by count and result register
module mmad_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mmad_pkg::q_status_t         q_status_i,
  input  mmad_pkg::frame_t            q_head_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [mmad_pkg::MeanW-1:0]  mean_q16_o,
  output logic                        no_overlap_o,
  output logic [mmad_pkg::CntW-1:0]   matched_count_o
);

  localparam int unsigned MW = mmad_pkg::MeanW;
  localparam int unsigned CNW = mmad_pkg::CntW;

  mmad_pkg::div_state_e     state_q, state_d;
  logic [mmad_pkg::StepW-1:0] step_q, step_d;
  logic [CNW-1:0]           rem_q, rem_d;
  logic [MW-1:0]            quo_q, quo_d;
  logic [CNW-1:0]           divisor_q, divisor_d;
  logic [CNW:0]             trial;
  logic                     qbit;

  logic                     out_valid_q, out_valid_d;
  logic [MW-1:0]            mean_q, mean_d;
  logic                     none_q, none_d;
  logic [CNW-1:0]           matched_q, matched_d;

  always_comb begin
    // remainder stays below the divisor, so one subtract per bit
    trial = {rem_q, quo_q[MW-1]};
    qbit  = trial >= {1'b0, divisor_q};

    state_d     = state_q;
    step_d      = step_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    divisor_d   = divisor_q;
    pop_o       = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    mean_d      = mean_q;
    none_d      = none_q;
    matched_d   = matched_q;

    unique case (state_q)
      mmad_pkg::DIV_IDLE: begin
        if (!q_status_i.empty) begin
          pop_o     = 1'b1;
          // upper dividend bits sum[39:16] preload the remainder
          rem_d     = CNW'(q_head_i.sum[mmad_pkg::SumW-1:mmad_pkg::PixW]);
          quo_d     = {q_head_i.sum[mmad_pkg::PixW-1:0], {mmad_pkg::FracW{1'b0}}};
          divisor_d = q_head_i.count;
          step_d    = '0;
          state_d   = mmad_pkg::DIV_RUN;
        end
      end
      mmad_pkg::DIV_RUN: begin
        rem_d  = qbit ? CNW'(trial - {1'b0, divisor_q}) : trial[CNW-1:0];
        quo_d  = {quo_q[MW-2:0], qbit};
        step_d = step_q + 1'b1;
        if (step_q == mmad_pkg::StepW'(mmad_pkg::DivSteps - 1)) begin
          state_d = mmad_pkg::DIV_DONE;
        end
      end
      mmad_pkg::DIV_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          if (divisor_q == '0) begin
            mean_d    = '0;
            none_d    = 1'b1;
            matched_d = '0;
          end else begin
            mean_d    = (CNW'(quo_q) > mmad_pkg::MeanMax) ? MW'(mmad_pkg::MeanMax) : quo_q;
            none_d    = 1'b0;
            matched_d = divisor_q;
          end
          state_d = mmad_pkg::DIV_IDLE;
        end
      end
      default: state_d = mmad_pkg::DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mmad_pkg::DIV_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    divisor_q <= divisor_d;
    mean_q    <= mean_d;
    none_q    <= none_d;
    matched_q <= matched_d;
  end

  assign out_valid_o     = out_valid_q;
  assign mean_q16_o      = mean_q;
  assign no_overlap_o    = none_q;
  assign matched_count_o = matched_q;

endmodule

// ===== rtl/masked_overlap_mean_abs_diff.sv =====
// top level: configuration registers, pixel front end, frame queue and divider
//
// Pixels are taken one per clock in raster order; the front end scores each pixel in the
// cycle it is accepted, so input ready only drops when a last-flagged word arrives while
// two finished frames already sit in the queue. Each frame result is then written to the
// queue, loaded into the divider, run through the bit-serial restoring divider (one
// quotient bit per cycle) and moved into the output register once any stalled result
// there has been taken. Short frames back the queue up, since the divider takes a new frame
// total only after finishing the last one. Configuration may only change between frames.
module masked_overlap_mean_abs_diff #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [mmad_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [mmad_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [mmad_pkg::PixW-1:0]          ref_red_i,
  input  logic [mmad_pkg::PixW-1:0]          ref_alpha_i,
  input  logic [mmad_pkg::PixW-1:0]          cand_red_i,
  input  logic [mmad_pkg::PixW-1:0]          cand_alpha_i,
  input  logic                               last_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [mmad_pkg::MeanW-1:0]         mean_q16_o,
  output logic                               no_overlap_o,
  output logic [mmad_pkg::CntW-1:0]          matched_count_o
);

  mmad_pkg::cfg_t      cfg_q, cfg_d;
  mmad_pkg::q_status_t q_status;
  mmad_pkg::frame_t    push_data, q_head;
  logic                push, pop;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mmad_pkg::REG_REF_WIDTH:   cfg_d.ref_width       = cfg_data_i[mmad_pkg::DimW-1:0];
        mmad_pkg::REG_CAND_WIDTH:  cfg_d.cand_width      = cfg_data_i[mmad_pkg::DimW-1:0];
        mmad_pkg::REG_CAND_HEIGHT: cfg_d.cand_height     = cfg_data_i[mmad_pkg::DimW-1:0];
        mmad_pkg::REG_OFFSET_X:    cfg_d.offset_x        = signed'(cfg_data_i[mmad_pkg::DimW-1:0]);
        mmad_pkg::REG_OFFSET_Y:    cfg_d.offset_y        = signed'(cfg_data_i[mmad_pkg::DimW-1:0]);
        mmad_pkg::REG_ALPHA_THR:   cfg_d.alpha_threshold = cfg_data_i;
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ref_width       <= mmad_pkg::RstRefWidth;
      cfg_q.cand_width      <= mmad_pkg::RstCandWidth;
      cfg_q.cand_height     <= mmad_pkg::RstCandHeight;
      cfg_q.offset_x        <= '0;
      cfg_q.offset_y        <= '0;
      cfg_q.alpha_threshold <= mmad_pkg::RstAlphaThr;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  mmad_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .ref_red_i    (ref_red_i),
    .ref_alpha_i  (ref_alpha_i),
    .cand_red_i   (cand_red_i),
    .cand_alpha_i (cand_alpha_i),
    .last_i       (last_i),
    .q_status_i   (q_status),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  mmad_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (q_head),
    .status_o    (q_status)
  );

  mmad_div u_div (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_status_i      (q_status),
    .q_head_i        (q_head),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .mean_q16_o      (mean_q16_o),
    .no_overlap_o    (no_overlap_o),
    .matched_count_o (matched_count_o)
  );

endmodule

// ===== rtl/mmad_checker.sv =====
// port-level checks for the masked overlap mean absolute difference block, with bind
module mmad_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               cfg_we_i,
  input logic [mmad_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input logic [mmad_pkg::CfgDataW-1:0]      cfg_data_i,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic [mmad_pkg::PixW-1:0]          ref_red_i,
  input logic [mmad_pkg::PixW-1:0]          ref_alpha_i,
  input logic [mmad_pkg::PixW-1:0]          cand_red_i,
  input logic [mmad_pkg::PixW-1:0]          cand_alpha_i,
  input logic                               last_i,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic [mmad_pkg::MeanW-1:0]         mean_q16_o,
  input logic                               no_overlap_o,
  input logic [mmad_pkg::CntW-1:0]          matched_count_o
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(mean_q16_o)
      && $stable(no_overlap_o) && $stable(matched_count_o))
    else $error("result word changed while stalled");

  // empty frame reports zero mean and zero count
  a_empty_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && no_overlap_o |-> mean_q16_o == '0 && matched_count_o == '0)
    else $error("no_overlap result with nonzero mean or count");

  // a matched frame has a count within the saturation limit
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !no_overlap_o |-> matched_count_o != '0
      && matched_count_o <= mmad_pkg::CntW'(16777216))
    else $error("matched count out of range");

  // mean never exceeds the largest pixel difference
  a_mean_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> mmad_pkg::CntW'(mean_q16_o) <= mmad_pkg::MeanMax)
    else $error("mean above full-scale difference");

  // only a last word can be refused
  a_ready_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !last_i |-> in_ready_o)
    else $error("plain pixel word refused");

endmodule

bind masked_overlap_mean_abs_diff mmad_checker u_mmad_checker (.*);
